// ----- rtl/r2hsv_pkg.sv -----
// ----------------------------------------------------------------------------
// r2hsv_pkg
// Types, constants and the divider step shared by the RGB to HSV converter.
// ----------------------------------------------------------------------------
package r2hsv_pkg;

    localparam int unsigned ChanW        = 8;
    localparam int unsigned HueQW        = 6;   // hue quotient is at most 43
    localparam int unsigned DivStages    = 4;   // two saturation bits per stage
    localparam int unsigned HueDivStages = 3;   // two hue bits per stage

    localparam logic [ChanW-1:0] HsvFull   = 8'd255;
    localparam logic [ChanW-1:0] HsvSixth  = 8'd43;
    localparam logic [ChanW-1:0] BaseRed   = 8'd0;
    localparam logic [ChanW-1:0] BaseGreen = 8'd85;
    localparam logic [ChanW-1:0] BaseBlue  = 8'd171;

    typedef struct packed {
        logic [ChanW-1:0] red_in;
        logic [ChanW-1:0] green_in;
        logic [ChanW-1:0] blue_in;
    } t_rgb_pix;

    typedef struct packed {
        logic [ChanW-1:0] hue_out;
        logic [ChanW-1:0] sat_out;
        logic [ChanW-1:0] val_out;
    } t_hsv_pix;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    // One item in flight through the divider stages.
    typedef struct packed {
        logic [ChanW-1:0] hi;      // value, also saturation divisor
        logic [ChanW-1:0] span;    // max - min, also hue divisor
        t_sector          sector;
        logic             neg;     // hue offset is negative
        logic [ChanW-1:0] s_rem;
        logic [ChanW-1:0] s_num;   // numerator bits not yet consumed
        logic [ChanW-1:0] s_q;
        logic [ChanW-1:0] h_rem;
        logic [HueQW-1:0] h_num;
        logic [HueQW-1:0] h_q;
    } t_work;

    // Two restoring division steps on the saturation divider, and on the hue divider when do_hue is set.
    function automatic t_work div_pair(input t_work w, input logic do_hue);
        t_work      n;
        logic [8:0] part;
        n = w;
        for (int k = 0; k < 2; k++) begin
            part    = {n.s_rem, n.s_num[ChanW-1]};
            n.s_num = {n.s_num[ChanW-2:0], 1'b0};
            if (part >= {1'b0, n.hi}) begin
                part  = part - {1'b0, n.hi};
                n.s_q = {n.s_q[ChanW-2:0], 1'b1};
            end else begin
                n.s_q = {n.s_q[ChanW-2:0], 1'b0};
            end
            n.s_rem = part[ChanW-1:0];
            if (do_hue) begin
                part    = {n.h_rem, n.h_num[HueQW-1]};
                n.h_num = {n.h_num[HueQW-2:0], 1'b0};
                if (part >= {1'b0, n.span}) begin
                    part  = part - {1'b0, n.span};
                    n.h_q = {n.h_q[HueQW-2:0], 1'b1};
                end else begin
                    n.h_q = {n.h_q[HueQW-2:0], 1'b0};
                end
                n.h_rem = part[ChanW-1:0];
            end
        end
        return n;
    endfunction

endpackage

// ----- rtl/rgb_to_hsv_8bit.sv -----
// ----------------------------------------------------------------------------
// rgb_to_hsv_8bit
// Pipelined 8-bit RGB to HSV pixel converter, one pixel per clock while the output is not stalled.
// ----------------------------------------------------------------------------
//  channel  dir  signals                   payload
//  input    in   i_valid / o_ready         i_pix (red_in, green_in, blue_in)
//  output   out  o_valid / i_ready         o_pix (hue_out, sat_out, val_out)
//
//  One pixel can transfer every cycle while the output accepts. The depth
//  is set by the two restoring dividers, which retire two quotient bits per
//  stage, saturation over four stages and hue over the first three.
//  Synchronous active-low reset clears every stage's valid bit.
//  Each stage holds while its successor is full and stalled, so bubbles
//  collapse and a stall neither drops nor repeats a pixel.
// ----------------------------------------------------------------------------
module rgb_to_hsv_8bit
    import r2hsv_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_rgb_pix i_pix,
    output logic     o_valid,
    input  logic     i_ready,
    output t_hsv_pix o_pix
);

    // ------------------------------------------------------------------
    // Stage A: largest channel, smallest channel, sector, hue difference
    // ------------------------------------------------------------------
    logic             r_a_valid;
    logic [ChanW-1:0] r_a_hi, r_a_lo, r_a_ad;
    t_sector          r_a_sector;
    logic             r_a_neg;

    logic [ChanW-1:0] n_a_hi, n_a_lo, n_a_ad;
    t_sector          n_a_sector;
    logic [ChanW:0]   a_diff;

    // Stage B: span and scaled numerators, loaded into divider form
    logic  r_b_valid;
    t_work r_b;
    t_work n_b;
    logic [2*ChanW-1:0] b_sat_num;
    logic [13:0]        b_hue_num;
    logic [ChanW-1:0]   b_span;

    // Divider stages
    logic  r_d_valid [DivStages];
    t_work r_d       [DivStages];
    logic  d_rdy     [DivStages];

    // Output register
    logic             r_o_valid;
    t_hsv_pix         r_o_pix;
    t_hsv_pix         n_o_pix;
    logic [ChanW-1:0] o_base, o_q;

    logic a_rdy, b_rdy, o_rdy;

    // ------------------------------------------------------------------
    // Ready chain: a stage may load when empty or when it drains this cycle
    // ------------------------------------------------------------------
    assign o_rdy = !r_o_valid || i_ready;

    always_comb begin
        d_rdy[DivStages-1] = !r_d_valid[DivStages-1] || o_rdy;
        for (int k = DivStages - 2; k >= 0; k--) begin
            d_rdy[k] = !r_d_valid[k] || d_rdy[k+1];
        end
    end

    assign b_rdy   = !r_b_valid || d_rdy[0];
    assign a_rdy   = !r_a_valid || b_rdy;
    assign o_ready = a_rdy;

    // ------------------------------------------------------------------
    // Stage A logic. Ties resolve red first, then green.
    // ------------------------------------------------------------------
    always_comb begin
        n_a_hi = i_pix.red_in;
        if (i_pix.green_in > n_a_hi) n_a_hi = i_pix.green_in;
        if (i_pix.blue_in > n_a_hi)  n_a_hi = i_pix.blue_in;
        n_a_lo = i_pix.red_in;
        if (i_pix.green_in < n_a_lo) n_a_lo = i_pix.green_in;
        if (i_pix.blue_in < n_a_lo)  n_a_lo = i_pix.blue_in;

        if (i_pix.red_in >= i_pix.green_in && i_pix.red_in >= i_pix.blue_in) begin
            n_a_sector = SEC_RED;
            a_diff     = {1'b0, i_pix.green_in} - {1'b0, i_pix.blue_in};
        end else if (i_pix.green_in >= i_pix.blue_in) begin
            n_a_sector = SEC_GREEN;
            a_diff     = {1'b0, i_pix.blue_in} - {1'b0, i_pix.red_in};
        end else begin
            n_a_sector = SEC_BLUE;
            a_diff     = {1'b0, i_pix.red_in} - {1'b0, i_pix.green_in};
        end
        // magnitude of the signed difference
        n_a_ad = a_diff[ChanW] ? ChanW'(-a_diff) : a_diff[ChanW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_rdy) begin
            r_a_valid <= i_valid;
        end
        if (a_rdy && i_valid) begin
            r_a_hi     <= n_a_hi;
            r_a_lo     <= n_a_lo;
            r_a_ad     <= n_a_ad;
            r_a_sector <= n_a_sector;
            r_a_neg    <= a_diff[ChanW];
        end
    end

    // ------------------------------------------------------------------
    // Stage B logic. Both quotients fit well below their numerator width,
    // so each divider starts with the top numerator bits as its remainder.
    // ------------------------------------------------------------------
    always_comb begin
        b_span    = r_a_hi - r_a_lo;
        b_sat_num = {b_span, 8'd0} - {8'd0, b_span};           // 255 * span
        b_hue_num = 14'(r_a_ad * HsvSixth);                     // 43 * |diff|

        n_b        = '0;
        n_b.hi     = r_a_hi;
        n_b.span   = b_span;
        n_b.sector = r_a_sector;
        n_b.neg    = r_a_neg;
        n_b.s_rem  = b_sat_num[2*ChanW-1:ChanW];
        n_b.s_num  = b_sat_num[ChanW-1:0];
        n_b.h_rem  = b_hue_num[13:HueQW];
        n_b.h_num  = b_hue_num[HueQW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_rdy) begin
            r_b_valid <= r_a_valid;
        end
        if (b_rdy && r_a_valid) begin
            r_b <= n_b;
        end
    end

    // ------------------------------------------------------------------
    // Divider stages: two quotient bits per stage, hue finishes early
    // ------------------------------------------------------------------
    for (genvar k = 0; k < DivStages; k++) begin : g_div
        logic  prev_valid;
        t_work prev;
        if (k == 0) begin : g_first
            assign prev_valid = r_b_valid;
            assign prev       = r_b;
        end else begin : g_rest
            assign prev_valid = r_d_valid[k-1];
            assign prev       = r_d[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_valid[k] <= 1'b0;
            end else if (d_rdy[k]) begin
                r_d_valid[k] <= prev_valid;
            end
            if (d_rdy[k] && prev_valid) begin
                r_d[k] <= div_pair(prev, 1'(k < HueDivStages));
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: grey or black pixels force hue and saturation to zero;
    // the hue offset adds to or drops from the sector base, wrapping mod 256.
    // ------------------------------------------------------------------
    always_comb begin
        case (r_d[DivStages-1].sector)
            SEC_RED:   o_base = BaseRed;
            SEC_GREEN: o_base = BaseGreen;
            SEC_BLUE:  o_base = BaseBlue;
            default:   o_base = BaseRed;
        endcase
        o_q = {2'b00, r_d[DivStages-1].h_q};

        n_o_pix.val_out = r_d[DivStages-1].hi;
        if (r_d[DivStages-1].span == '0) begin
            n_o_pix.sat_out = '0;
            n_o_pix.hue_out = '0;
        end else begin
            n_o_pix.sat_out = r_d[DivStages-1].s_q;
            n_o_pix.hue_out = r_d[DivStages-1].neg ? o_base - o_q : o_base + o_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_rdy) begin
            r_o_valid <= r_d_valid[DivStages-1];
        end
        if (o_rdy && r_d_valid[DivStages-1]) begin
            r_o_pix <= n_o_pix;
        end
    end

    assign o_valid = r_o_valid;
    assign o_pix   = r_o_pix;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_grey_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pix.sat_out == '0 |-> o_pix.hue_out == '0)
        else $error("hue not zero on a grey pixel");

    a_black_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pix.val_out == '0 |-> o_pix.sat_out == '0)
        else $error("saturation not zero on a black pixel");

    a_hue_quot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_valid[DivStages-1] && r_d[DivStages-1].span != '0
        |-> r_d[DivStages-1].h_q <= HueQW'(HsvSixth))
        else $error("hue quotient out of range");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !r_a_valid && !r_b_valid)
        else $error("pipeline not empty after reset");

endmodule

// ----- tb/rgb_to_hsv_8bit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_8bit_tb
// Self-checking bench for the pipelined 8-bit RGB to HSV converter. Pixels
// go in over valid/ready, first from a short table of corner cases and then
// at random. A behavioral model of the conversion, or a typed-in value for
// some table rows, predicts each result, and the predictions are compared
// field by field with the output transfers. Both sides idle and stall at
// random. One long receiver hold-off backs up the pipeline.
// ----------------------------------------------------------------------------
module rgb_to_hsv_8bit_tb;
    import r2hsv_pkg::*;

    localparam int  HalfPeriod   = 6;          // 12 ns clock
    localparam int  ResetCycles  = 7;
    localparam int  RandomPixels = 400;
    localparam int  LongHoldOff  = 80;         // receiver hold-off, in cycles
    localparam int  DrainCycles  = 20;         // margin after the last expected result
    localparam int  HueSixth     = 43;
    localparam int  HueGreen     = 85;
    localparam int  HueBlue      = 171;
    localparam int  FullScale    = 255;

    // One row of the directed table. Where hsv_fixed is set, the expected
    // result is typed in. Otherwise the behavioral model supplies it.
    typedef struct {
        t_rgb_pix pix;
        bit       hsv_fixed;
        t_hsv_pix hsv;
    } t_probe_row;

    logic     i_clk   = 1'b0;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_ready;
    t_rgb_pix i_pix;
    logic     o_valid;
    logic     i_ready;
    t_hsv_pix o_pix;

    t_hsv_pix   hsv_expected [$];   // predicted results, oldest first
    t_probe_row probe_rows   [$];

    int  mismatch_count     = 0;
    int  pixels_sent        = 0;
    int  results_checked    = 0;
    int  input_stall_cycles = 0;
    bit  no_idle            = 1'b0;  // set for the last part of the run
    bit  rx_long_req        = 1'b0;  // ask the receiver for one long hold-off

    rgb_to_hsv_8bit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_pix   (i_pix),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_pix   (o_pix)
    );

    always #HalfPeriod i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Behavioral model: value is the largest channel, saturation scales the
    // spread against it, and hue is a sector base plus a truncated offset.
    // SystemVerilog int division truncates toward zero, as the hue offset
    // requires. The low 8 bits of the sum give the wrap modulo 256.
    // ------------------------------------------------------------------------
    function automatic t_hsv_pix hsv_of(input t_rgb_pix pix);
        t_hsv_pix res;
        int       red;
        int       grn;
        int       blu;
        int       top;
        int       bot;
        int       spread;
        int       hue;
        int       sat;
        red = int'(pix.red_in);
        grn = int'(pix.green_in);
        blu = int'(pix.blue_in);
        top = red;
        bot = red;
        hue = 0;
        sat = 0;
        if (grn > top) top = grn;
        if (blu > top) top = blu;
        if (grn < bot) bot = grn;
        if (blu < bot) bot = blu;
        spread = top - bot;
        if (top != 0) begin
            sat = (FullScale * spread) / top;
            if (sat != 0) begin
                // Ties go to red first, then to green.
                if (top == red) begin
                    hue = (HueSixth * (grn - blu)) / spread;
                end else if (top == grn) begin
                    hue = HueGreen + (HueSixth * (blu - red)) / spread;
                end else begin
                    hue = HueBlue + (HueSixth * (red - grn)) / spread;
                end
            end
        end
        res.hue_out = hue[7:0];
        res.sat_out = sat[7:0];
        res.val_out = top[7:0];
        return res;
    endfunction

    function automatic t_rgb_pix mk_rgb(input int r, input int g, input int b);
        t_rgb_pix pix;
        pix.red_in   = r[7:0];
        pix.green_in = g[7:0];
        pix.blue_in  = b[7:0];
        return pix;
    endfunction

    // Pick a channel value that is either an extreme or random.
    function automatic int edge_or_any();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 255;
            default: return int'($urandom_range(0, 255));
        endcase
    endfunction

    // Random pixel, biased toward ties, greys, extremes and narrow spreads,
    // where the sector choice and the truncation matter most.
    function automatic t_rgb_pix rand_pixel();
        t_rgb_pix pix;
        int       base;
        int       pick;
        pick = $urandom_range(0, 7);
        case (pick)
            0, 1, 2: begin
                pix = mk_rgb($urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 255));
            end
            3: begin
                pix = mk_rgb(edge_or_any(), edge_or_any(), edge_or_any());
            end
            4: begin
                // two channels equal, which one is the third is random
                base = edge_or_any();
                case ($urandom_range(0, 2))
                    0:       pix = mk_rgb(base, base, $urandom_range(0, 255));
                    1:       pix = mk_rgb(base, $urandom_range(0, 255), base);
                    default: pix = mk_rgb($urandom_range(0, 255), base, base);
                endcase
            end
            5: begin
                base = $urandom_range(0, 255);
                pix  = mk_rgb(base, base, base);
            end
            default: begin
                // narrow spread: span of a few counts
                base = $urandom_range(0, 250);
                pix  = mk_rgb(base + $urandom_range(0, 5), base + $urandom_range(0, 5),
                              base + $urandom_range(0, 5));
            end
        endcase
        return pix;
    endfunction

    task automatic add_row(input int r, input int g, input int b, input bit fixed,
                           input int h, input int s, input int v);
        t_probe_row row;
        row.pix         = mk_rgb(r, g, b);
        row.hsv_fixed   = fixed;
        row.hsv.hue_out = h[7:0];
        row.hsv.sat_out = s[7:0];
        row.hsv.val_out = v[7:0];
        probe_rows.push_back(row);
    endtask

    // Offer one pixel and hold it until the transfer. The caller is at a
    // rising edge, so the new payload is a single nonblocking update.
    task automatic send_pixel(input t_rgb_pix pix, input t_hsv_pix hsv);
        i_valid <= 1'b1;
        i_pix   <= pix;
        do @(posedge i_clk); while (!o_ready);
        hsv_expected.push_back(hsv);
        pixels_sent++;
    endtask

    // Drop valid for a random burst, unless idling is off.
    task automatic sender_gap();
        int gap;
        if (!no_idle && ($urandom_range(0, 4) == 0)) begin
            gap = $urandom_range(1, 8);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sender: reset, the directed table, then the random stream.
    // ------------------------------------------------------------------------
    initial begin : tx_side
        t_rgb_pix pix;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_pix   <= '0;
        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Corner cases with results that can be read off directly.
        add_row(  0,   0,   0, 1,   0,   0,   0);   // black, first after reset
        add_row(255, 255, 255, 1,   0,   0, 255);   // white
        add_row(128, 128, 128, 1,   0,   0, 128);   // grey
        add_row(  1,   1,   1, 1,   0,   0,   1);   // darkest grey
        add_row(255,   0,   0, 1,   0, 255, 255);   // pure red
        add_row(  0, 255,   0, 1,  85, 255, 255);   // pure green
        add_row(  0,   0, 255, 1, 171, 255, 255);   // pure blue
        add_row(255,   0, 255, 1, 213, 255, 255);   // red wins tie, hue wraps
        add_row(255, 255,   0, 1,  43, 255, 255);   // red wins over green
        add_row(  0, 255, 255, 1, 128, 255, 255);   // green wins over blue
        // Everything else goes through the model.
        add_row(  1,   0,   0, 0, 0, 0, 0);         // smallest nonzero value
        add_row(255, 254, 254, 0, 0, 0, 0);         // span of one at full value
        add_row(255,   0,   1, 0, 0, 0, 0);         // tiny negative offset
        add_row(255,   0, 200, 0, 0, 0, 0);         // large negative offset
        add_row(  0,   1,   0, 0, 0, 0, 0);
        add_row(254, 255, 255, 0, 0, 0, 0);         // green ties blue
        add_row(  1, 255, 254, 0, 0, 0, 0);
        add_row(200, 100, 150, 0, 0, 0, 0);
        add_row( 90,  20, 250, 0, 0, 0, 0);
        add_row(170,  85,   0, 0, 0, 0, 0);
        add_row(8'hAA, 8'h55, 8'hFF, 0, 0, 0, 0);   // alternating bit patterns
        add_row(8'h55, 8'hAA, 8'h00, 0, 0, 0, 0);
        add_row(  0, 128, 255, 0, 0, 0, 0);

        foreach (probe_rows[k]) begin
            if (probe_rows[k].hsv_fixed) begin
                send_pixel(probe_rows[k].pix, probe_rows[k].hsv);
            end else begin
                send_pixel(probe_rows[k].pix, hsv_of(probe_rows[k].pix));
            end
            sender_gap();
        end

        // Pause until the table has fully drained.
        i_valid <= 1'b0;
        wait (hsv_expected.size() == 0);
        @(posedge i_clk);

        for (int n = 0; n < RandomPixels; n++) begin
            if (n == 120) begin
                // Hold off the receiver and keep offering back to back, so
                // the pipeline fills and o_ready falls.
                rx_long_req = 1'b1;
                no_idle     = 1'b1;
            end
            if (n == 120 + LongHoldOff) no_idle = 1'b0;
            if (n == 260) begin
                i_valid <= 1'b0;
                wait (hsv_expected.size() == 0);
                @(posedge i_clk);
            end
            if (n == RandomPixels - 60) no_idle = 1'b1;   // no idling at the end
            pix = rand_pixel();
            send_pixel(pix, hsv_of(pix));
            sender_gap();
        end
        i_valid <= 1'b0;

        // Drain, then a few more cycles for anything unexpected.
        wait (hsv_expected.size() == 0);
        repeat (DrainCycles) @(posedge i_clk);

        $display("Converted %0d pixels (%0d from the corner table), checked %0d results,",
                 pixels_sent, probe_rows.size(), results_checked);
        $display("input held back by the pipeline for %0d cycles.", input_stall_cycles);
        if (mismatch_count == 0 && hsv_expected.size() == 0) begin
            $display("rgb_to_hsv_8bit_tb: PASS");
        end else begin
            $display("rgb_to_hsv_8bit_tb: FAIL");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: ready drops in random bursts, plus one long hold-off on
    // request. The hold-off is counted here, independent of the sender.
    // ------------------------------------------------------------------------
    initial begin : rx_side
        int hold;
        hold = 0;
        i_ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (rx_long_req) begin
                rx_long_req = 1'b0;
                hold        = LongHoldOff - 1;
                i_ready    <= 1'b0;
            end else if (!no_idle && ($urandom_range(0, 5) == 0)) begin
                hold     = $urandom_range(1, 8) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output check: each output transfer against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_hsv_pix want;
        if (i_rst_n) begin
            if (i_valid && !o_ready) input_stall_cycles++;
            if (o_valid && i_ready) begin
                if (hsv_expected.size() == 0) begin
                    $display("%0t: result with nothing expected: hue %0d sat %0d val %0d",
                             $time, o_pix.hue_out, o_pix.sat_out, o_pix.val_out);
                    mismatch_count++;
                end else begin
                    want = hsv_expected.pop_front();
                    results_checked++;
                    if (o_pix.hue_out !== want.hue_out) begin
                        $display("%0t: hue_out mismatch: expected %0d, actual %0d",
                                 $time, want.hue_out, o_pix.hue_out);
                        mismatch_count++;
                    end
                    if (o_pix.sat_out !== want.sat_out) begin
                        $display("%0t: sat_out mismatch: expected %0d, actual %0d",
                                 $time, want.sat_out, o_pix.sat_out);
                        mismatch_count++;
                    end
                    if (o_pix.val_out !== want.val_out) begin
                        $display("%0t: val_out mismatch: expected %0d, actual %0d",
                                 $time, want.val_out, o_pix.val_out);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Watchdog: well beyond the slowest legal run.
    initial begin : watchdog
        #2_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, hsv_expected.size());
        $display("rgb_to_hsv_8bit_tb: FAIL");
        $finish;
    end

endmodule
